>>> rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int unsigned HEAP_BLOCKS_DEF  = 4096;
  localparam int unsigned MAX_SEGMENTS_DEF = 2048;

  localparam int unsigned REQ_W = 13;
  localparam int unsigned GRANT_W = 12;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Controller to datapath commands
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_LATCH    = 4'd1,  // capture request, clear scan index
    CMD_RD_SEG   = 4'd2,  // read segment at scan index
    CMD_STEP     = 4'd3,  // advance scan index
    CMD_RD_REG   = 4'd4,  // read region length at target
    CMD_TRIM     = 4'd5,  // trim segment at index
    CMD_SHL      = 4'd6,  // shift entries left by one (one entry a cycle)
    CMD_SHR      = 4'd7,  // shift entries right by one
    CMD_WR_REG   = 4'd8,  // write region length
    CMD_RD_PREV  = 4'd9,  // read segment index-1
    CMD_JOIN     = 4'd10, // apply coalesce
    CMD_INSERT   = 4'd11, // write new segment at index
    CMD_CLR      = 4'd12, // clear region table entry (sweep)
    CMD_DONE     = 4'd13,
    CMD_SHPRE    = 4'd14, // fetch first entry to move in a shift
    CMD_SEG0     = 4'd15  // write first segment covering the heap
  } cmd_t;

  typedef struct packed {
    cmd_t    cmd;
    status_t st;
  } ffa_ctl_t;

  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic bad_target;
    logic idx_end;     // scan index == count
    logic fits;        // current segment length >= n
    logic exact;       // current segment length == n
    logic before_t;    // current segment start < target
    logic reg_zero;    // recorded length is zero
    logic join_prev;
    logic join_next;
    logic table_full;
    logic shift_done;
    logic clr_done;
  } ffa_sts_t;

endpackage

>>> rtl/ffa_ram.sv
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ffa_datapath.sv
module ffa_datapath
  import ffa_pkg::*;
#(
  parameter int unsigned HEAP_BLOCKS  = HEAP_BLOCKS_DEF,
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ffa_ctl_t           ctl,
  input  logic               in_req_type,
  input  logic [REQ_W-1:0]   in_alloc_blocks,
  input  logic [REQ_W-1:0]   in_target_block,
  output ffa_sts_t           sts,
  output logic [1:0]         out_status,
  output logic [GRANT_W-1:0] out_granted_block
);

  localparam int unsigned AW = (HEAP_BLOCKS > 1) ? $clog2(HEAP_BLOCKS) : 1;
  localparam int unsigned LW = $clog2(HEAP_BLOCKS + 1);
  localparam int unsigned SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned EW = AW + LW;  // segment entry: start, length
  localparam int unsigned XW = (LW > REQ_W ? LW : REQ_W) + 1;
  localparam logic [LW-1:0] HEAP_L = LW'(HEAP_BLOCKS);
  localparam logic [CW-1:0] MAXS_C = CW'(MAX_SEGMENTS);

  // request and scan registers
  logic             free_r;
  logic [REQ_W-1:0] n_r, t_r;
  logic [CW-1:0]    idx_r, idx_nxt, cnt_r, sh_r, sh_nxt;
  logic             shl_r;        // shift direction: 1 left (removal), 0 right
  logic [AW-1:0]    cs_r, ps_r;   // current / previous segment start
  logic [LW-1:0]    cl_r, pl_r, rl_r;
  logic [1:0]       st_r;
  logic [GRANT_W-1:0] gb_r;
  logic [AW:0]      clr_r;
  logic             clr_busy_r;

  // segment table memory
  logic           seg_we;
  logic [SW-1:0]  seg_wa, seg_ra;
  logic [EW-1:0]  seg_wd, seg_rd;
  // region length memory
  logic           reg_we;
  logic [AW-1:0]  reg_wa, reg_ra;
  logic [LW-1:0]  reg_wd, reg_rd;

  ffa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_seg (
    .clk(clk), .we(seg_we), .waddr(seg_wa), .wdata(seg_wd),
    .raddr(seg_ra), .rdata(seg_rd)
  );
  ffa_ram #(.WIDTH(LW), .DEPTH(HEAP_BLOCKS)) u_reg (
    .clk(clk), .we(reg_we), .waddr(reg_wa), .wdata(reg_wd),
    .raddr(reg_ra), .rdata(reg_rd)
  );

  logic [XW-1:0] t_ext, n_ext, cl_ext, pend_ext, tend_ext, cs_ext;
  assign t_ext    = XW'(t_r);
  assign n_ext    = XW'(n_r);
  assign cl_ext   = XW'(cl_r);
  assign cs_ext   = XW'(cs_r);
  assign pend_ext = XW'(ps_r) + XW'(pl_r);
  assign tend_ext = t_ext + XW'(rl_r);

  // status to controller
  always_comb begin
    sts.is_free    = free_r;
    sts.zero_req   = (n_r == '0);
    sts.bad_target = (t_ext >= XW'(HEAP_BLOCKS));
    sts.idx_end    = (idx_r == cnt_r);
    sts.fits       = (cl_ext >= n_ext);
    sts.exact      = (cl_ext == n_ext);
    sts.before_t   = (cs_ext < t_ext);
    sts.reg_zero   = (rl_r == '0);
    sts.join_prev  = (idx_r != '0) && (pend_ext == t_ext);
    sts.join_next  = (idx_r != cnt_r) && (tend_ext == cs_ext);
    sts.table_full = (cnt_r >= MAXS_C);
    // left shift runs against the already reduced count
    sts.shift_done = shl_r ? (sh_r >= cnt_r) : (sh_r == idx_r);
    sts.clr_done   = !clr_busy_r;
  end

  // memory addressing
  always_comb begin
    seg_we = 1'b0;
    seg_wa = SW'(idx_r);
    seg_wd = {cs_r, cl_r};
    seg_ra = SW'(idx_r);
    reg_we = 1'b0;
    reg_wa = AW'(t_r);
    reg_wd = '0;
    reg_ra = AW'(t_r);
    case (ctl.cmd)
      CMD_RD_SEG:  seg_ra = SW'(idx_r);
      CMD_RD_PREV: seg_ra = SW'(idx_r - CW'(1));
      CMD_TRIM: begin
        seg_we = 1'b1;
        seg_wd = {cs_r + AW'(n_r), cl_r - LW'(n_r)};
      end
      CMD_SHPRE: seg_ra = shl_r ? SW'(sh_r + CW'(1)) : SW'(sh_r - CW'(1));
      CMD_SHL: begin
        // move entry sh+1 down to sh; read was issued the cycle before
        seg_ra = SW'(sh_r + CW'(2));
        seg_we = 1'b1;
        seg_wa = SW'(sh_r);
        seg_wd = seg_rd;
      end
      CMD_SHR: begin
        seg_ra = SW'(sh_r - CW'(2));
        seg_we = 1'b1;
        seg_wa = SW'(sh_r);
        seg_wd = seg_rd;
      end
      CMD_JOIN: begin
        seg_we = 1'b1;
        if (sts.join_prev) begin
          seg_wa = SW'(idx_r - CW'(1));
          seg_wd = {ps_r, pl_r + rl_r + (sts.join_next ? cl_r : LW'(0))};
        end else begin
          seg_wd = {AW'(t_r), cl_r + rl_r};
        end
      end
      CMD_INSERT: begin
        seg_we = 1'b1;
        seg_wd = {AW'(t_r), rl_r};
      end
      CMD_SEG0: begin
        seg_we = 1'b1;
        seg_wa = '0;
        seg_wd = {{AW{1'b0}}, HEAP_L};
      end
      CMD_WR_REG: begin
        reg_we = 1'b1;
        reg_wa = free_r ? AW'(t_r) : cs_r;
        reg_wd = free_r ? LW'(0) : LW'(n_r);
      end
      CMD_CLR: begin
        reg_we = 1'b1;
        reg_wa = clr_r[AW-1:0];
      end
      default: ;
    endcase
    if (ctl.cmd == CMD_LATCH) begin
      // prime reads for either path
      seg_ra = '0;
      reg_ra = AW'(in_target_block);
    end
    if (ctl.cmd == CMD_STEP) seg_ra = SW'(idx_r + CW'(1));
  end

  // index / shift pointer
  always_comb begin
    idx_nxt = idx_r;
    sh_nxt  = sh_r;
    case (ctl.cmd)
      CMD_LATCH: idx_nxt = '0;
      CMD_STEP:  idx_nxt = idx_r + CW'(1);
      CMD_TRIM:  sh_nxt = idx_r;
      CMD_JOIN:  sh_nxt = idx_r;
      CMD_RD_PREV: sh_nxt = free_r ? cnt_r : idx_r;
      CMD_SHL:   sh_nxt = sh_r + CW'(1);
      CMD_SHR:   sh_nxt = sh_r - CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= CW'(1);
      clr_r      <= '0;
      clr_busy_r <= 1'b1;
      st_r       <= ST_OK;
      gb_r       <= '0;
    end else begin
      if (ctl.cmd == CMD_CLR) begin
        clr_r <= clr_r + (AW+1)'(1);
        if (clr_r == (AW+1)'(HEAP_BLOCKS - 1)) clr_busy_r <= 1'b0;
      end
      // count drops as soon as a removal starts
      if (ctl.cmd == CMD_INSERT) cnt_r <= cnt_r + CW'(1);
      else if ((ctl.cmd == CMD_JOIN && sts.join_prev && sts.join_next) ||
               (ctl.cmd == CMD_TRIM && sts.exact))
        cnt_r <= cnt_r - CW'(1);
      if (ctl.cmd == CMD_DONE) begin
        st_r <= ctl.st;
        gb_r <= (ctl.st == ST_OK && !free_r) ? GRANT_W'(cs_r) : '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sh_r  <= sh_nxt;
    if (ctl.cmd == CMD_LATCH) begin
      free_r <= in_req_type;
      n_r    <= in_alloc_blocks;
      t_r    <= in_target_block;
    end
    if (ctl.cmd == CMD_RD_REG) rl_r <= reg_rd;
    if (ctl.cmd == CMD_RD_SEG) {cs_r, cl_r} <= seg_rd;
    if (ctl.cmd == CMD_STEP) {ps_r, pl_r} <= {cs_r, cl_r};
    if (ctl.cmd == CMD_TRIM || ctl.cmd == CMD_JOIN) shl_r <= 1'b1;
    if (ctl.cmd == CMD_RD_PREV) shl_r <= 1'b0;
  end

  // result word
  assign out_status        = st_r;
  assign out_granted_block = gb_r;

endmodule

>>> rtl/ffa_ctrl.sv
module ffa_ctrl
  import ffa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ffa_sts_t sts,
  output ffa_ctl_t ctl
);

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RDWT  = 12'b000000000100,
    S_CHK   = 12'b000000001000,
    S_RDSEG = 12'b000000010000,
    S_RDPV  = 12'b000000100000,
    S_SHPRE = 12'b000001000000,
    S_SHIFT = 12'b000010000000,
    S_REG   = 12'b000100000000,
    S_DONE  = 12'b001000000000,
    S_OUT   = 12'b010000000000,
    S_SEG0  = 12'b100000000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    shr_r, shr_nxt;   // direction of pending shift
  logic    post_r, post_nxt; // action after shift: 0 region write, 1 insert

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    shr_nxt   = shr_r;
    post_nxt  = post_r;
    ctl.cmd   = CMD_NONE;
    ctl.st    = st_r;
    case (state_r)
      S_CLR: begin
        ctl.cmd = CMD_CLR;
        if (!sts.clr_done) state_nxt = S_CLR;
        else state_nxt = S_SEG0;
      end
      S_SEG0: begin
        ctl.cmd = CMD_SEG0;
        state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        ctl.cmd = CMD_LATCH;
        st_nxt = ST_OK;
        state_nxt = S_RDWT;
      end
      S_RDWT: begin
        ctl.cmd = sts.is_free ? CMD_RD_REG : CMD_RD_SEG;
        state_nxt = S_CHK;
        if (!sts.is_free && sts.zero_req) begin
          st_nxt = ST_INVALID;
          state_nxt = S_DONE;
        end else if (sts.is_free && sts.bad_target) begin
          st_nxt = ST_INVALID;
          state_nxt = S_DONE;
        end else if (sts.is_free) begin
          ctl.cmd = CMD_RD_REG;
          state_nxt = S_RDSEG;
        end
      end
      S_RDSEG: begin
        // load scanned segment; on a free the region length is known here
        ctl.cmd = CMD_RD_SEG;
        if (sts.is_free && sts.reg_zero) begin
          st_nxt = ST_INVALID;
          state_nxt = S_DONE;
        end else state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!sts.is_free) begin
          if (sts.idx_end) begin
            st_nxt = ST_NOFIT;
            state_nxt = S_DONE;
          end else if (sts.fits) begin
            if (sts.exact) begin
              ctl.cmd = CMD_TRIM;
              shr_nxt = 1'b0;
              post_nxt = 1'b0;
              state_nxt = S_SHPRE;
            end else begin
              ctl.cmd = CMD_TRIM;
              state_nxt = S_REG;
            end
          end else begin
            ctl.cmd = CMD_STEP;
            state_nxt = S_RDSEG;
          end
        end else begin
          if (!sts.idx_end && sts.before_t) begin
            ctl.cmd = CMD_STEP;
            state_nxt = S_RDSEG;
          end else begin
            state_nxt = S_RDPV;
          end
        end
      end
      S_RDPV: begin
        if (sts.join_prev || sts.join_next) begin
          ctl.cmd = CMD_JOIN;
          if (sts.join_prev && sts.join_next) begin
            shr_nxt = 1'b0;
            post_nxt = 1'b0;
            state_nxt = S_SHPRE;
          end else state_nxt = S_REG;
        end else if (sts.table_full) begin
          st_nxt = ST_INVALID;
          state_nxt = S_DONE;
        end else begin
          ctl.cmd = CMD_RD_PREV;
          shr_nxt = 1'b1;
          post_nxt = 1'b1;
          state_nxt = S_SHPRE;
        end
      end
      S_SHPRE: begin
        ctl.cmd = CMD_SHPRE;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.shift_done) state_nxt = post_r ? S_DONE : S_REG;
        else ctl.cmd = shr_r ? CMD_SHR : CMD_SHL;
        if (sts.shift_done && post_r) ctl.cmd = CMD_INSERT;
        if (sts.shift_done && post_r) state_nxt = S_REG;
      end
      S_REG: begin
        ctl.cmd = CMD_WR_REG;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ctl.cmd = CMD_DONE;
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      st_r    <= ST_OK;
      shr_r   <= 1'b0;
      post_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      shr_r   <= shr_nxt;
      post_r  <= post_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept during output");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule

>>> rtl/first_fit_block_allocator.sv
// A request rejected up front ends without a scan. An allocate scans the segment
// table from its first entry and trims the first segment that fits; a free scans to
// its target and merges with neighbouring segments or inserts a new one. Removing
// or inserting a segment shifts the table entries behind it. The next word is taken the
// cycle after the result word leaves. Reset (rst_n synchronous, active low) runs a
// clearing pass over the region table; no word is taken before it ends.
module first_fit_block_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned HEAP_BLOCKS  = HEAP_BLOCKS_DEF,
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [REQ_W-1:0]   in_alloc_blocks,
  input  logic [REQ_W-1:0]   in_target_block,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [GRANT_W-1:0] out_granted_block
);

  ffa_ctl_t ctl;
  ffa_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .ctl(ctl)
  );

  ffa_datapath #(.HEAP_BLOCKS(HEAP_BLOCKS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .in_req_type(in_req_type), .in_alloc_blocks(in_alloc_blocks),
    .in_target_block(in_target_block), .sts(sts),
    .out_status(out_status), .out_granted_block(out_granted_block)
  );

endmodule
